[rtl/mstt_pkg.sv]
package mstt_pkg;

	// Bank geometry
	localparam int SLOTS      = 8;
	localparam int COUNT_BITS = 16;

	// Fixed field widths of the ports
	localparam int OP_W    = 2;
	localparam int TAG_W   = 16;
	localparam int DLY_W   = 16;
	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 3;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W = (COUNT_BITS > DLY_W) ? COUNT_BITS : DLY_W;

	// All ones marks a free slot
	localparam logic [COUNT_BITS-1:0] FREE_MARK = {COUNT_BITS{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_TICK = 2'd0,
		OP_ADD  = 2'd1,
		OP_SERV = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_NONE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_ADD,
		ST_SERV
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic  load;
		logic  idx_inc;
		logic  tick_upd;
		logic  add_wr;
		logic  serv_free;
		logic  emit;
		kind_t emit_kind;
		logic  emit_acc;
		logic  emit_last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cur_free;
		logic cur_due;
		logic due_above;
		logic idx_last;
		logic out_free;
	} sts_t;

	// Slot index reported modulo the slot field
	function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[SLOT_W-1:0];
	endfunction

endpackage

[rtl/mstt_ctrl.sv]
module mstt_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [mstt_pkg::OP_W-1:0] op,
	output logic                     in_ready,
	input  mstt_pkg::sts_t           sts,
	output mstt_pkg::cmd_t           cmd
);
	import mstt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(op))
						OP_TICK: state_d = ST_TICK;
						OP_ADD:  state_d = ST_ADD;
						OP_SERV: state_d = ST_SERV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK: begin
				if (sts.idx_last) state_d = ST_IDLE;
			end
			ST_ADD: begin
				if ((sts.cur_free || sts.idx_last) && sts.out_free) state_d = ST_IDLE;
			end
			ST_SERV: begin
				if (sts.cur_due) begin
					if (sts.out_free && !sts.due_above) state_d = ST_IDLE;
				end else if (sts.idx_last && sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.emit_kind = KIND_ADD;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_TICK: begin
				cmd.tick_upd = 1'b1;
				cmd.idx_inc  = !sts.idx_last;
			end
			ST_ADD: begin
				if (sts.cur_free) begin
					if (sts.out_free) begin
						cmd.add_wr    = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_ADD;
						cmd.emit_acc  = 1'b1;
						cmd.emit_last = 1'b1;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_ADD;
						cmd.emit_last = 1'b1;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_SERV: begin
				if (sts.cur_due) begin
					if (sts.out_free) begin
						cmd.serv_free = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_FIRED;
						cmd.emit_last = !sts.due_above;
						cmd.idx_inc   = sts.due_above;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_NONE;
						cmd.emit_last = 1'b1;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/mstt_dp.sv]
module mstt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mstt_pkg::cmd_t               cmd,
	output mstt_pkg::sts_t               sts,
	input  logic [mstt_pkg::TAG_W-1:0]   task_tag,
	input  logic [mstt_pkg::DLY_W-1:0]   delay_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mstt_pkg::KIND_W-1:0]  kind,
	output logic                         accepted,
	output logic [mstt_pkg::SLOT_W-1:0]  slot,
	output logic [mstt_pkg::TAG_W-1:0]   fired_tag,
	output logic                         last
);
	import mstt_pkg::*;

	logic [COUNT_BITS-1:0] count_q [SLOTS];
	logic [TAG_W-1:0]      tag_q   [SLOTS];
	logic [SLOTS-1:0]      due_q;

	logic [IDX_W-1:0]      idx_q;
	logic [TAG_W-1:0]      new_tag_q;
	logic [COUNT_BITS-1:0] new_dly_q;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic                  accepted_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [TAG_W-1:0]      fired_tag_q;
	logic                  last_q;

	logic [COUNT_BITS-1:0] cur_cnt;
	logic [CMP_W-1:0]      dly_wide;
	logic [COUNT_BITS-1:0] dly_sat;
	logic [SLOTS-1:0]      due_hi;

	assign cur_cnt  = count_q[idx_q];
	assign dly_wide = CMP_W'(delay_ticks);
	assign dly_sat  = (dly_wide >= CMP_W'(FREE_MARK)) ? (FREE_MARK - 1'b1)
	                                                  : COUNT_BITS'(dly_wide);

	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			due_hi[j] = due_q[j] && (j > int'(idx_q));
		end
	end

	assign sts.cur_free  = (cur_cnt == FREE_MARK);
	assign sts.cur_due   = due_q[idx_q];
	assign sts.due_above = |due_hi;
	assign sts.idx_last  = (idx_q == IDX_W'(SLOTS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// Item latch and slot walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_tag_q <= task_tag;
			new_dly_q <= dly_sat;
		end
	end

	// Slot bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				count_q[i] <= FREE_MARK;
			end
			due_q <= '0;
		end else begin
			if (cmd.tick_upd && cur_cnt != FREE_MARK) begin
				if (cur_cnt == '0) begin
					due_q[idx_q] <= 1'b1;
				end else begin
					count_q[idx_q] <= cur_cnt - 1'b1;
				end
			end
			if (cmd.add_wr) begin
				count_q[idx_q] <= new_dly_q;
			end
			if (cmd.serv_free) begin
				count_q[idx_q] <= FREE_MARK;
				due_q[idx_q]   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			tag_q[idx_q] <= new_tag_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q      <= cmd.emit_kind;
			accepted_q  <= cmd.emit_acc;
			last_q      <= cmd.emit_last;
			slot_q      <= (cmd.emit_acc || cmd.emit_kind == KIND_FIRED) ? slot_field(idx_q)
			                                                            : '0;
			fired_tag_q <= (cmd.emit_kind == KIND_FIRED) ? tag_q[idx_q] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign accepted  = accepted_q;
	assign slot      = slot_q;
	assign fired_tag = fired_tag_q;
	assign last      = last_q;

endmodule

[rtl/multi_slot_oneshot_task_timer_top.sv]
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------
// in      | in_valid / in_ready  | op, task_tag, delay_ticks
// out     | out_valid / out_ready| kind, accepted, slot, fired_tag, last
//
// One slot is visited per cycle unless the walker stalls on the result
// register: a tick walks all SLOTS slots, an add walks up to the lowest free
// slot (or all SLOTS), a service stops after the highest due slot. After each
// walk the sequencer is idle again and takes the next beat. Op 3 is dropped
// in idle, so the next beat can follow it on the very next cycle.
// arst_n frees every slot and clears all due flags at once.
// A result waits in the output register; the walker stalls on the next
// result only while that register is still full and out_ready is low.
module multi_slot_oneshot_task_timer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mstt_pkg::OP_W-1:0]    op,
	input  logic [mstt_pkg::TAG_W-1:0]   task_tag,
	input  logic [mstt_pkg::DLY_W-1:0]   delay_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mstt_pkg::KIND_W-1:0]  kind,
	output logic                         accepted,
	output logic [mstt_pkg::SLOT_W-1:0]  slot,
	output logic [mstt_pkg::TAG_W-1:0]   fired_tag,
	output logic                         last
);
	import mstt_pkg::*;

	// Command and status between the sequencer and the slot bank
	cmd_t cmd;
	sts_t sts;

	// Sequencer: decodes the op and steps through the slots
	mstt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot bank, item latch and result register
	mstt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.task_tag    (task_tag),
		.delay_ticks (delay_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.accepted    (accepted),
		.slot        (slot),
		.fired_tag   (fired_tag),
		.last        (last)
	);

endmodule
